FILE: design/cpli_pkg.sv
package cpli_pkg;

    localparam int TIME_W      = 20;
    localparam int VAL_W       = 16;
    localparam int BP_W        = TIME_W + VAL_W;
    localparam int PTS_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = BP_W;
    localparam int FRAC_W      = 17;
    localparam int WIDE_W      = TIME_W + 2;
    localparam int DIV_CNT_W   = 5;

    localparam int DEFAULT_MAX_POINTS = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BP_BASE = 3'd2;

    localparam logic [TIME_W-1:0] PERIOD_RST = 20'd24000;
    localparam logic [PTS_W-1:0]  POINTS_RST = 3'd6;
    localparam logic [PTS_W-1:0]  POINTS_MIN = 3'd2;

    localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'h10000;
    localparam logic [FRAC_W-1:0] FRAC_ZERO = 17'h00000;

    localparam logic [DIV_CNT_W-1:0] DIV_MOD_STEPS  = 5'd22;
    localparam logic [DIV_CNT_W-1:0] DIV_FRAC_STEPS = 5'd16;

    typedef struct packed {
        logic                   start;
        logic [TIME_W-1:0]      rem0;
        logic [WIDE_W-1:0]      dvd;
        logic [TIME_W-1:0]      dvs;
        logic [DIV_CNT_W-1:0]   steps;
    } t_div_req;

    typedef struct packed {
        logic                   busy;
        logic                   done;
        logic [VAL_W-1:0]       quo;
        logic [TIME_W-1:0]      rem;
    } t_div_rsp;

endpackage

FILE: design/cpli_ifs.sv
interface cpli_in_if;
    import cpli_pkg::*;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] query_time;
    modport source (output valid, output query_time, input ready);
    modport sink   (input valid, input query_time, output ready);
endinterface

interface cpli_out_if;
    import cpli_pkg::*;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] interp_value;
    modport source (output valid, output interp_value, input ready);
    modport sink   (input valid, input interp_value, output ready);
endinterface

interface cpli_cfg_if;
    import cpli_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/cyclic_piecewise_linear_interp_unit.sv
// Flow: the breakpoint search looks at the breakpoints one at a time; one shared
//   restoring divider then runs 22 steps for the wrap-around modulo and 16 steps
//   for the Q0.16 fraction, before the multiply and the registered result.
// Input ready returns once the result is registered, so a new query is taken only after it,
//   later while an earlier result is still waiting for the sink.
// Reset: synchronous active-low; registers return to their reset values, control idles.
module cyclic_piecewise_linear_interp_unit #(
    parameter int MAX_POINTS = cpli_pkg::DEFAULT_MAX_POINTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cpli_in_if.sink     i_in,
    cpli_out_if.source  o_out,
    cpli_cfg_if.sink    i_cfg
);
    import cpli_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int PROD_W = FRAC_W + FRAC_W + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LAST  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_PICKP = 4'd3;
    localparam logic [3:0] S_PICKN = 4'd4;
    localparam logic [3:0] S_SETUP = 4'd5;
    localparam logic [3:0] S_START = 4'd6;
    localparam logic [3:0] S_MOD   = 4'd7;
    localparam logic [3:0] S_FRAC  = 4'd8;
    localparam logic [3:0] S_MUL   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]               r_state, n_state;
    logic                     r_out_valid, n_out_valid;
    logic [VAL_W-1:0]         r_out_val, n_out_val;
    logic [TIME_W-1:0]        r_q, n_q;
    logic [IW-1:0]            r_k, n_k;
    logic [IW-1:0]            r_prev, n_prev;
    logic [IW-1:0]            r_next, n_next;
    logic [TIME_W-1:0]        r_tp, n_tp;
    logic [TIME_W-1:0]        r_ts, n_ts;
    logic [VAL_W-1:0]         r_vp, n_vp;
    logic [VAL_W-1:0]         r_vs, n_vs;
    logic                     r_wrap, n_wrap;
    logic                     r_neg, n_neg;
    logic [WIDE_W-1:0]        r_den, n_den;
    logic [WIDE_W-1:0]        r_num, n_num;
    logic [FRAC_W-1:0]        r_frac, n_frac;
    logic signed [PROD_W-1:0] r_prod, n_prod;

    logic [TIME_W-1:0] period;
    logic [IW-1:0]     last;
    logic [IW-1:0]     rd_sel;
    logic [TIME_W-1:0] rd_time;
    logic [VAL_W-1:0]  rd_val;
    t_div_req          div_req;
    t_div_rsp          div_rsp;
    logic              wrap_now;
    logic              den_pos;
    logic signed [FRAC_W-1:0]  vdiff;
    logic signed [PROD_W-1:0]  res_full;

    cpli_cfg #(
        .MAX_POINTS (MAX_POINTS)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_rd_sel  (rd_sel),
        .o_period  (period),
        .o_last    (last),
        .o_rd_time (rd_time),
        .o_rd_val  (rd_val)
    );

    cpli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        case (r_state)
            S_LAST:  rd_sel = last;
            S_SCAN:  rd_sel = r_k;
            S_PICKP: rd_sel = r_prev;
            S_PICKN: rd_sel = r_next;
            default: rd_sel = r_k;
        endcase
    end

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.interp_value = r_out_val;

    assign wrap_now = (r_ts < r_tp);
    assign den_pos  = !r_den[WIDE_W-1] && (r_den != '0);
    assign vdiff    = $signed({1'b0, r_vs}) - $signed({1'b0, r_vp});
    // vp + floor((vs - vp) * frac / 2^16)
    assign res_full = $signed({{(PROD_W-VAL_W){1'b0}}, r_vp}) + (r_prod >>> VAL_W);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_val   = r_out_val;
        n_q         = r_q;
        n_k         = r_k;
        n_prev      = r_prev;
        n_next      = r_next;
        n_tp        = r_tp;
        n_ts        = r_ts;
        n_vp        = r_vp;
        n_vs        = r_vs;
        n_wrap      = r_wrap;
        n_neg       = r_neg;
        n_den       = r_den;
        n_num       = r_num;
        n_frac      = r_frac;
        n_prod      = r_prod;
        div_req     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_q     = i_in.query_time;
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_k = '0;
                if (r_q >= rd_time) begin
                    n_prev  = last;
                    n_next  = '0;
                    n_state = S_PICKP;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // ends at or before the last point, whose time is above the query
                if (rd_time >= r_q) begin
                    if (r_k == '0) begin
                        n_prev = last;
                        n_next = '0;
                    end else begin
                        n_prev = r_k - IW'(1);
                        n_next = r_k;
                    end
                    n_state = S_PICKP;
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            S_PICKP: begin
                n_tp    = rd_time;
                n_vp    = rd_val;
                n_state = S_PICKN;
            end
            S_PICKN: begin
                n_ts    = rd_time;
                n_vs    = rd_val;
                n_state = S_SETUP;
            end
            S_SETUP: begin
                n_wrap  = wrap_now;
                n_den   = {2'b00, r_ts} + (wrap_now ? {2'b00, period} : '0) - {2'b00, r_tp};
                n_num   = {2'b00, r_q} + (wrap_now ? {2'b00, period} : '0) - {2'b00, r_tp};
                n_state = S_START;
            end
            S_START: begin
                if (!den_pos) begin
                    n_frac  = FRAC_ONE;
                    n_state = S_MUL;
                end else if (r_wrap) begin
                    // modulo of the wrapped offset by the period
                    div_req.start = 1'b1;
                    div_req.rem0  = '0;
                    div_req.dvd   = r_num[WIDE_W-1] ? (~r_num + WIDE_W'(1)) : r_num;
                    div_req.dvs   = period;
                    div_req.steps = DIV_MOD_STEPS;
                    n_neg   = r_num[WIDE_W-1];
                    n_state = S_MOD;
                end else if (r_num[WIDE_W-1]) begin
                    n_frac  = FRAC_ZERO;
                    n_state = S_MUL;
                end else if (r_num >= r_den) begin
                    n_frac  = FRAC_ONE;
                    n_state = S_MUL;
                end else begin
                    div_req.start = 1'b1;
                    div_req.rem0  = r_num[TIME_W-1:0];
                    div_req.dvd   = '0;
                    div_req.dvs   = r_den[TIME_W-1:0];
                    div_req.steps = DIV_FRAC_STEPS;
                    n_state = S_FRAC;
                end
            end
            S_MOD: begin
                if (div_rsp.done) begin
                    if (r_neg && div_rsp.rem != '0) begin
                        n_num = {2'b00, period} - {2'b00, div_rsp.rem};
                    end else begin
                        n_num = {2'b00, div_rsp.rem};
                    end
                    n_wrap  = 1'b0;
                    n_state = S_START;
                end
            end
            S_FRAC: begin
                if (div_rsp.done) begin
                    n_frac  = {1'b0, div_rsp.quo};
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = vdiff * $signed({1'b0, r_frac});
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_val   = res_full[VAL_W-1:0];
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_val <= n_out_val;
        r_q       <= n_q;
        r_k       <= n_k;
        r_prev    <= n_prev;
        r_next    <= n_next;
        r_tp      <= n_tp;
        r_ts      <= n_ts;
        r_vp      <= n_vp;
        r_vs      <= n_vs;
        r_wrap    <= n_wrap;
        r_neg     <= n_neg;
        r_den     <= n_den;
        r_num     <= n_num;
        r_frac    <= n_frac;
        r_prod    <= n_prod;
    end

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k <= last))
        else $error("breakpoint scan ran past the last point");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_frac <= FRAC_ONE))
        else $error("fraction above one");

    a_frac_div_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRAC) |-> (!r_num[WIDE_W-1] && r_num < r_den))
        else $error("fraction division started with offset not below span");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_LAST))
        else $error("accepted query did not start the search");

    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside the output step");

endmodule

FILE: design/cpli_cfg.sv
module cpli_cfg #(
    parameter int MAX_POINTS = cpli_pkg::DEFAULT_MAX_POINTS,
    localparam int IW = $clog2(MAX_POINTS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cpli_cfg_if.sink                      i_cfg,
    input  logic [IW-1:0]                 i_rd_sel,
    output logic [cpli_pkg::TIME_W-1:0]   o_period,
    output logic [IW-1:0]                 o_last,
    output logic [cpli_pkg::TIME_W-1:0]   o_rd_time,
    output logic [cpli_pkg::VAL_W-1:0]    o_rd_val
);
    import cpli_pkg::*;

    logic [TIME_W-1:0]    r_period;
    logic [PTS_W-1:0]     r_points;
    logic [BP_W-1:0]      r_bp [MAX_POINTS];
    logic                 wr;
    logic                 is_bp;
    logic [CFG_IDX_W-1:0] slot;
    logic [PTS_W-1:0]     n_eff;

    assign i_cfg.ready = 1'b1;
    assign wr    = i_cfg.valid && i_cfg.ready;
    assign is_bp = (i_cfg.index >= REG_BP_BASE);
    assign slot  = i_cfg.index - REG_BP_BASE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
            r_points <= POINTS_RST;
            for (int j = 0; j < MAX_POINTS; j++) begin
                r_bp[j] <= '0;
            end
        end else if (wr) begin
            if (i_cfg.index == REG_PERIOD) begin
                r_period <= i_cfg.data[TIME_W-1:0];
            end
            if (i_cfg.index == REG_POINTS) begin
                r_points <= i_cfg.data[PTS_W-1:0];
            end
            for (int j = 0; j < MAX_POINTS; j++) begin
                if (is_bp && slot == CFG_IDX_W'(j)) begin
                    r_bp[j] <= i_cfg.data;
                end
            end
        end
    end

    // point count clamped to 2..MAX_POINTS, period 0 acts as 1
    always_comb begin
        if (r_points < POINTS_MIN) begin
            n_eff = POINTS_MIN;
        end else if (r_points > PTS_W'(MAX_POINTS)) begin
            n_eff = PTS_W'(MAX_POINTS);
        end else begin
            n_eff = r_points;
        end
    end

    assign o_last    = IW'(n_eff - 3'd1);
    assign o_period  = (r_period == '0) ? TIME_W'(1) : r_period;
    assign o_rd_time = r_bp[i_rd_sel][BP_W-1:VAL_W];
    assign o_rd_val  = r_bp[i_rd_sel][VAL_W-1:0];

endmodule

FILE: design/cpli_div.sv
module cpli_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpli_pkg::t_div_req  i_req,
    output cpli_pkg::t_div_rsp  o_rsp
);
    import cpli_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [TIME_W-1:0]    r_rem, n_rem;
    logic [WIDE_W-1:0]    r_dvd, n_dvd;
    logic [TIME_W-1:0]    r_dvs, n_dvs;
    logic [VAL_W-1:0]     r_quo, n_quo;
    logic [TIME_W:0]      trial;
    logic [TIME_W:0]      diff;
    logic                 ge;

    // restoring step: bring down one dividend bit, subtract if it fits
    assign trial = {r_rem, r_dvd[WIDE_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = (trial >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_quo  = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.steps;
            n_rem  = i_req.rem0;
            n_dvd  = i_req.dvd;
            n_dvs  = i_req.dvs;
            n_quo  = '0;
        end else if (r_busy) begin
            n_rem = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
            n_dvd = {r_dvd[WIDE_W-2:0], 1'b0};
            n_quo = {r_quo[VAL_W-2:0], ge};
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_rem_below_dvs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dvs))
        else $error("divider remainder not below divisor");

endmodule

FILE: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpli_pkg::*;

    localparam int BP_REGS     = 6;
    localparam int NPTS        = DEFAULT_MAX_POINTS;
    localparam int SEGMENTS    = 32;
    localparam int SEG_QUERIES = 50;
    localparam int DRAIN_WAIT  = 60;
    localparam longint FULL_SCALE = FRAC_ONE;

    typedef struct {
        logic [TIME_W-1:0] query;
        logic [VAL_W-1:0]  level;
    } t_expected_level;

    // Mirrors the register file and predicts each interpolated value.
    class interp_checker;
        logic [TIME_W-1:0] period_len;
        logic [PTS_W-1:0]  points;
        logic [BP_W-1:0]   bp [BP_REGS];
        t_expected_level   levels [$];
        int                errors;

        function new();
            period_len = PERIOD_RST;
            points     = POINTS_RST;
            foreach (bp[k]) bp[k] = '0;
            errors = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR @%0t: %s", $time, msg);
        endtask

        function void note_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PERIOD: begin
                    period_len = data[TIME_W-1:0];
                end
                REG_POINTS: begin
                    points = data[PTS_W-1:0];
                end
                default: begin
                    bp[idx - REG_BP_BASE] = data;
                end
            endcase
        endfunction

        function int used_points();
            int n;
            n = int'(points);
            if (n < 2) n = 2;
            if (n > NPTS) n = NPTS;
            return n;
        endfunction

        function longint bp_time(int k);
            return longint'(bp[k][BP_W-1:VAL_W]);
        endfunction

        function logic [VAL_W-1:0] interp_level(logic [TIME_W-1:0] q);
            longint qv, per, tp, ts, num, den, frac, vp, vs, mix;
            int n, prev, nxt, k;
            qv   = longint'(q);
            per  = (period_len == 0) ? 1 : longint'(period_len);
            n    = used_points();
            prev = n - 1;
            nxt  = 0;
            // later point is the first one at or after q; else wrap last -> first
            if (qv < bp_time(n - 1)) begin
                k = 0;
                while (k < n && bp_time(k) < qv) k++;
                if (k > 0 && k < n) begin
                    prev = k - 1;
                    nxt  = k;
                end
            end
            tp = bp_time(prev);
            ts = bp_time(nxt);
            vp = longint'(bp[prev][VAL_W-1:0]);
            vs = longint'(bp[nxt][VAL_W-1:0]);
            if (ts < tp) begin
                num = (qv + per - tp) % per;
                if (num < 0) num += per;
                den = ts + per - tp;
            end else begin
                num = qv - tp;
                den = ts - tp;
            end
            if (den <= 0) begin
                frac = FULL_SCALE;
            end else begin
                if (num < 0) num = 0;
                frac = (num << 16) / den;
                if (frac > FULL_SCALE) frac = FULL_SCALE;
            end
            mix = (vs * frac + vp * (FULL_SCALE - frac)) >> 16;
            return mix[VAL_W-1:0];
        endfunction

        function void note_query(logic [TIME_W-1:0] q);
            t_expected_level e;
            e.query = q;
            e.level = interp_level(q);
            levels.push_back(e);
        endfunction

        task check_level(logic [VAL_W-1:0] got);
            t_expected_level want;
            if (levels.size() == 0) begin
                report($sformatf("result %h with no query outstanding", got));
                return;
            end
            want = levels.pop_front();
            if (got !== want.level)
                report($sformatf("query %0d: interp_value %h, expected %h",
                                 want.query, got, want.level));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    cpli_in_if  in_if ();
    cpli_out_if out_if ();
    cpli_cfg_if cfg_if ();

    cyclic_piecewise_linear_interp_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    interp_checker   board;
    int              src_idle_pct;
    int              sink_idle_pct;
    logic [BP_W-1:0] plan_bp [BP_REGS];

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) board.note_query(in_if.query_time);
        if (i_rst_n && out_if.valid && out_if.ready) board.check_level(out_if.interp_value);
    end

    // valid stays high across back-to-back writes; dropped once after the last
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        board.note_reg(idx, data);
    endtask

    task automatic program_block(input logic [TIME_W-1:0] per, input logic [PTS_W-1:0] pts);
        logic [CFG_DATA_W-1:0] data;
        int k;
        // junk above the field width must be ignored
        data = CFG_DATA_W'({$urandom, $urandom});
        data[TIME_W-1:0] = per;
        write_reg(REG_PERIOD, data);
        data = CFG_DATA_W'({$urandom, $urandom});
        data[PTS_W-1:0] = pts;
        write_reg(REG_POINTS, data);
        for (k = 0; k < BP_REGS; k++)
            write_reg(REG_BP_BASE + CFG_IDX_W'(k), plan_bp[k]);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_query(input logic [TIME_W-1:0] q);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.query_time <= q;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic finish_batch();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (board.levels.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [BP_W-1:0] point(int t, int v);
        return {TIME_W'(t), VAL_W'(v)};
    endfunction

    task automatic random_setup();
        int per, nn, lo, hi, span, t, style, k;
        logic [VAL_W-1:0] v;
        logic [PTS_W-1:0] pts;
        style = $urandom_range(99);
        case ($urandom_range(4))
            0: per = $urandom_range(40, 1);
            1: per = 1048575;
            2: per = 24000;
            default: per = $urandom_range(1048575, 1);
        endcase
        if (style < 4) per = 0;
        pts = PTS_W'($urandom_range(NPTS, 2));
        if (style < 12) pts = PTS_W'($urandom);
        nn = (pts < 2) ? 2 : (pts > NPTS) ? NPTS : int'(pts);
        lo = 0;
        for (k = 0; k < BP_REGS; k++) begin
            hi = per - nn + k;
            if (k < nn && hi >= lo) begin
                span = (hi - lo) / (nn - k) * 2;
                if (span > hi - lo) span = hi - lo;
                t  = lo + $urandom_range(span);
                lo = t + 1;
            end else begin
                t = $urandom_range(1048575);
            end
            if ($urandom_range(4) == 0)
                v = $urandom_range(1) ? '1 : '0;
            else
                v = VAL_W'($urandom);
            plan_bp[k] = {TIME_W'(t), v};
            // a share of setups with unordered breakpoints
            if (style >= 88) plan_bp[k] = BP_W'({$urandom, $urandom});
        end
        program_block(TIME_W'(per), pts);
    endtask

    task automatic random_queries(input int count);
        int per, nn, idx, pick, k;
        logic [TIME_W-1:0] q;
        per = int'(board.period_len);
        nn  = board.used_points();
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                q = (per == 0) ? '0 : TIME_W'($urandom_range(per - 1));
            end else if (pick < 90) begin
                idx = $urandom_range(nn - 1);
                q = board.bp[idx][BP_W-1:VAL_W] + TIME_W'($urandom_range(2)) - TIME_W'(1);
            end else begin
                q = TIME_W'($urandom);
            end
            send_query(q);
        end
        finish_batch();
    endtask

    initial begin
        int seg;
        board = new();
        src_idle_pct  = 6;
        sink_idle_pct = 57;
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.query_time <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= '0;
        cfg_if.data      <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values: all breakpoints at zero
        send_query('0);
        send_query('1);
        finish_batch();

        // ordered points with value extremes, wrap before first and after last
        plan_bp[0] = point(3000, 16'h0000);
        plan_bp[1] = point(9000, 16'hFFFF);
        plan_bp[2] = point(15000, 16'h1000);
        plan_bp[3] = point(21000, 16'h8000);
        plan_bp[4] = '1;
        plan_bp[5] = '1;
        program_block(20'd24000, 3'd4);
        send_query(20'd0);
        send_query(20'd3000);
        send_query(20'd6000);
        send_query(20'd9000);
        send_query(20'd12345);
        send_query(20'd21000);
        send_query(20'd23999);
        send_query('1);
        finish_batch();

        // zero span, point count below two
        plan_bp[0] = point(500, 16'h1234);
        plan_bp[1] = point(500, 16'hABCD);
        program_block(20'd1000, 3'd1);
        send_query(20'd500);
        send_query(20'd100);
        finish_batch();

        // zero period, point count above limit, negative wrap span
        plan_bp[0] = point(2, 16'h0100);
        plan_bp[1] = point(5, 16'h0200);
        plan_bp[2] = point(9, 16'h0300);
        plan_bp[3] = point(20, 16'h0400);
        plan_bp[4] = point(40, 16'h0500);
        plan_bp[5] = point(1048575, 16'hFFFF);
        program_block(20'd0, 3'd7);
        send_query(20'd0);
        send_query(20'd3);
        send_query(20'd30);
        send_query('1);
        finish_batch();

        // query ahead of the earlier point, clamped
        plan_bp[0] = point(900, 16'h2000);
        plan_bp[1] = point(100, 16'h4000);
        plan_bp[2] = point(500, 16'h6000);
        program_block(20'd1000, 3'd3);
        send_query(20'd200);
        finish_batch();

        // query past the period: fraction saturates
        plan_bp[0] = point(100, 16'h1111);
        plan_bp[1] = point(900, 16'hEEEE);
        program_block(20'd1000, 3'd2);
        send_query(20'd1500);
        send_query(20'd950);
        send_query(20'd50);
        finish_batch();

        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == SEGMENTS / 3) begin
                src_idle_pct  = 57;
                sink_idle_pct = 6;
            end else if (seg == 2 * SEGMENTS / 3) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            random_setup();
            random_queries(SEG_QUERIES);
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
